// ----- rtl/core/obbt_pkg.sv -----
// ----------------------------------------------------------------------------
// obbt_pkg
// Shared types, widths and helpers for the oriented box transform and
// axis projection core.
// ----------------------------------------------------------------------------
package obbt_pkg;

  // Field and register widths
  localparam int VEC_W     = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int E_W    = 17;  // point minus center
  localparam int PROD_W = 33;  // 17 x 16 signed product
  localparam int ACC_W  = 35;  // sum of three products plus center term
  localparam int CV_W   = 33;  // center dot axis
  localparam int MAG_W  = 33;  // magnitude of an axis dot basis
  localparam int TERM_W = 49;  // magnitude times half size
  localparam int SPAN_W = 51;  // sum of three half-span terms
  localparam int CTR_W  = 48;  // center projection plus rounding half
  localparam int FIN_W  = 53;  // center projection plus/minus span
  localparam int SHR_W  = 25;  // value after the rounding shift

  localparam int FRAC_LIN  = 14;
  localparam int FRAC_PROJ = 28;

  localparam logic [ACC_W:0]   LIN_HALF  = (ACC_W + 1)'(2 ** (FRAC_LIN - 1));
  localparam logic [CTR_W-1:0] PROJ_HALF = CTR_W'(2 ** (FRAC_PROJ - 1));

  // Operation codes
  typedef enum logic [1:0] {
    OP_W2L  = 2'd0,
    OP_L2W  = 2'd1,
    OP_PROJ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER  = 3'd0,
    CFG_HALF    = 3'd1,
    CFG_BASIS_I = 3'd2,
    CFG_BASIS_J = 3'd3,
    CFG_BASIS_K = 3'd4
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] BASIS_I_RST = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] BASIS_J_RST = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] BASIS_K_RST = 48'h4000_0000_0000;

  // Input beat
  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic signed [VEC_W-1:0] range_min;
    logic signed [VEC_W-1:0] range_max;
  } out_beat_t;

  // Box configuration
  typedef struct packed {
    logic [CFG_W-1:0] center;
    logic [CFG_W-1:0] half_size;
    logic [CFG_W-1:0] basis_i;
    logic [CFG_W-1:0] basis_j;
    logic [CFG_W-1:0] basis_k;
  } cfg_t;

  // Beat between front and back halves of the pipeline
  typedef struct packed {
    op_e                       op;
    logic [2:0][ACC_W-1:0]     acc;
    logic [CV_W-1:0]           cvs;
  } mid_t;

  // One 16-bit field of a packed register, x in the low bits
  function automatic logic [VEC_W-1:0] fld(input logic [CFG_W-1:0] p,
                                           input logic [1:0] idx);
    logic [VEC_W-1:0] r;
    case (idx)
      2'd0:    r = p[15:0];
      2'd1:    r = p[31:16];
      2'd2:    r = p[47:32];
      default: r = p[15:0];
    endcase
    return r;
  endfunction

  // Saturate a shifted value to signed 16 bits
  function automatic logic signed [VEC_W-1:0] sat16(input logic signed [SHR_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if ((v[SHR_W-1:VEC_W-1] == '0) || (v[SHR_W-1:VEC_W-1] == '1)) begin
      r = v[VEC_W-1:0];
    end else if (v[SHR_W-1]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7fff;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/obbt_front.sv -----
// ----------------------------------------------------------------------------
// obbt_front
// Stages 1-3: operand select, the nine basis products plus the center
// products, then row / column sums.
// ----------------------------------------------------------------------------
module obbt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  obbt_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  obbt_pkg::in_beat_t in_beat_i,
  output logic             mid_valid_o,
  input  logic             mid_stall_i,
  output obbt_pkg::mid_t   mid_o
);
  import obbt_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic signed [VEC_W-1:0] c [3];
  logic signed [VEC_W-1:0] b [3][3];

  // Stage 1
  op_e                     op1_q;
  logic signed [VEC_W-1:0] vin [3];
  logic signed [VEC_W-1:0] vin1_q [3];
  logic signed [E_W-1:0]   e1_d [3];
  logic signed [E_W-1:0]   e1_q [3];

  // Stage 2
  op_e                      op2_q;
  logic signed [E_W-1:0]    xsel [3][3];
  logic signed [PROD_W-1:0] m2_d [3][3];
  logic signed [PROD_W-1:0] m2_q [3][3];
  logic signed [CV_W-1:0]   cv2_d [3];
  logic signed [CV_W-1:0]   cv2_q [3];

  // Stage 3
  op_e                     op3_q;
  logic signed [ACC_W-1:0] acc3_d [3];
  logic signed [ACC_W-1:0] acc3_q [3];
  logic signed [CV_W-1:0]  cvs3_d;
  logic signed [CV_W-1:0]  cvs3_q;

  // Stall chain: a stage moves when it is empty or the next one moves
  assign en3        = !v3_q || !mid_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // Unpack box fields
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c[a]    = fld(cfg_i.center, 2'(a));
      b[0][a] = fld(cfg_i.basis_i, 2'(a));
      b[1][a] = fld(cfg_i.basis_j, 2'(a));
      b[2][a] = fld(cfg_i.basis_k, 2'(a));
    end
  end

  // Stage 1: point minus center for world to local
  always_comb begin
    vin[0] = in_beat_i.vec_x;
    vin[1] = in_beat_i.vec_y;
    vin[2] = in_beat_i.vec_z;
    for (int a = 0; a < 3; a++) begin
      if (op_e'(in_beat_i.opcode) == OP_W2L) begin
        e1_d[a] = E_W'(vin[a]) - E_W'(c[a]);
      end else begin
        e1_d[a] = E_W'(vin[a]);
      end
    end
  end

  // Stage 2: products; local to world weights basis n by v[n]
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      for (int a = 0; a < 3; a++) begin
        if (op1_q == OP_L2W) begin
          xsel[n][a] = E_W'(vin1_q[n]);
        end else begin
          xsel[n][a] = e1_q[a];
        end
        m2_d[n][a] = PROD_W'(xsel[n][a]) * PROD_W'(b[n][a]);
      end
      cv2_d[n] = CV_W'(vin1_q[n]) * CV_W'(c[n]);
    end
  end

  // Stage 3: row sums (dot with a basis) or column sums plus center
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      if (op2_q == OP_L2W) begin
        acc3_d[n] = ACC_W'(m2_q[0][n]) + ACC_W'(m2_q[1][n]) + ACC_W'(m2_q[2][n])
                  + (ACC_W'(c[n]) <<< FRAC_LIN);
      end else begin
        acc3_d[n] = ACC_W'(m2_q[n][0]) + ACC_W'(m2_q[n][1]) + ACC_W'(m2_q[n][2]);
      end
    end
    cvs3_d = cv2_q[0] + cv2_q[1] + cv2_q[2];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      op1_q  <= op_e'(in_beat_i.opcode);
      vin1_q <= vin;
      e1_q   <= e1_d;
    end
    if (en2 && v1_q) begin
      op2_q <= op1_q;
      m2_q  <= m2_d;
      cv2_q <= cv2_d;
    end
    if (en3 && v2_q) begin
      op3_q  <= op2_q;
      acc3_q <= acc3_d;
      cvs3_q <= cvs3_d;
    end
  end

  always_comb begin
    mid_o.op = op3_q;
    for (int n = 0; n < 3; n++) begin
      mid_o.acc[n] = acc3_q[n];
    end
    mid_o.cvs = cvs3_q;
  end

  assign mid_valid_o = v3_q;

endmodule

// ----- rtl/core/obbt_back.sv -----
// ----------------------------------------------------------------------------
// obbt_back
// Stages 4-6: rounding of transformed points, half-span terms of the
// projection, span sum, then extremes, rounding and output register.
// ----------------------------------------------------------------------------
module obbt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  obbt_pkg::cfg_t      cfg_i,
  input  logic                mid_valid_i,
  output logic                mid_stall_o,
  input  obbt_pkg::mid_t      mid_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obbt_pkg::out_beat_t out_beat_o
);
  import obbt_pkg::*;

  logic v4_q, v5_q, v6_q;
  logic en4, en5, en6;

  logic [VEC_W-1:0] h [3];

  // Stage 4
  op_e                     op4_q;
  logic signed [ACC_W-1:0] acc_s [3];
  logic signed [ACC_W-1:0] mag_full [3];
  logic signed [ACC_W:0]   lin_sum [3];
  logic [TERM_W-1:0]       t4_d [3];
  logic [TERM_W-1:0]       t4_q [3];
  logic signed [VEC_W-1:0] lin4_d [3];
  logic signed [VEC_W-1:0] lin4_q [3];
  logic signed [CTR_W-1:0] ctr4_d;
  logic signed [CTR_W-1:0] ctr4_q;

  // Stage 5
  op_e                     op5_q;
  logic [SPAN_W-1:0]       span5_q;
  logic signed [CTR_W-1:0] ctr5_q;
  logic signed [VEC_W-1:0] lin5_q [3];

  // Stage 6
  logic signed [FIN_W-1:0] span_s;
  logic signed [FIN_W-1:0] hi;
  logic signed [FIN_W-1:0] lo;
  out_beat_t               out_d;
  out_beat_t               out_q;

  assign en6         = !v6_q || !out_stall_i;
  assign en5         = !v5_q || en6;
  assign en4         = !v4_q || en5;
  assign mid_stall_o = !en4;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      h[a] = fld(cfg_i.half_size, 2'(a));
    end
  end

  // Stage 4: round points; |dot(axis, basis)| times half size
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      acc_s[n]    = $signed(mid_i.acc[n]);
      mag_full[n] = acc_s[n][ACC_W-1] ? -acc_s[n] : acc_s[n];
      t4_d[n]     = TERM_W'(mag_full[n][MAG_W-1:0]) * TERM_W'(h[n]);
      lin_sum[n]  = (ACC_W + 1)'(acc_s[n]) + $signed(LIN_HALF);
      lin4_d[n]   = sat16(SHR_W'($signed(lin_sum[n][ACC_W:FRAC_LIN])));
    end
    ctr4_d = (CTR_W'($signed(mid_i.cvs)) <<< FRAC_LIN) + $signed(PROJ_HALF);
  end

  // Stage 6: extremes of the corner projections, round and saturate
  always_comb begin
    span_s = $signed(FIN_W'(span5_q));
    hi     = FIN_W'(ctr5_q) + span_s;
    lo     = FIN_W'(ctr5_q) - span_s;
    out_d  = '0;
    case (op5_q) inside
      OP_W2L, OP_L2W: begin
        out_d.out_x = lin5_q[0];
        out_d.out_y = lin5_q[1];
        out_d.out_z = lin5_q[2];
      end
      OP_PROJ: begin
        out_d.range_min = sat16(lo[FIN_W-1:FRAC_PROJ]);
        out_d.range_max = sat16(hi[FIN_W-1:FRAC_PROJ]);
      end
      default: out_d = '0;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= mid_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en4 && mid_valid_i) begin
      op4_q  <= mid_i.op;
      t4_q   <= t4_d;
      lin4_q <= lin4_d;
      ctr4_q <= ctr4_d;
    end
    if (en5 && v4_q) begin
      op5_q   <= op4_q;
      span5_q <= SPAN_W'(t4_q[0]) + SPAN_W'(t4_q[1]) + SPAN_W'(t4_q[2]);
      ctr5_q  <= ctr4_q;
      lin5_q  <= lin4_q;
    end
    if (en6 && v5_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_beat_o  = out_q;

endmodule

// ----- rtl/core/obb_transform_and_axis_projection_core.sv -----
// ----------------------------------------------------------------------------
// obb_transform_and_axis_projection_core
// Oriented 3D box unit: world to local, local to world and projection of
// the box onto an axis, one beat per cycle while not stalled.
// ----------------------------------------------------------------------------
// The core takes one beat every cycle while not stalled and returns its
// result beat in order after the six register stages of the multiply and
// sum datapath; an empty stage lets a new beat enter while a finished
// result is still stalled. The user must write box registers through the
// cfg port only while no beat is in flight; the core does not enforce it;
// index 0 center, 1 half sizes, 2..4 the i, j, k bases; others are ignored.
module obb_transform_and_axis_projection_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [obbt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [obbt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  obbt_pkg::in_beat_t           in_beat_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output obbt_pkg::out_beat_t          out_beat_o
);
  import obbt_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  logic mid_valid;
  logic mid_stall;
  mid_t mid;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER:  cfg_d.center    = cfg_wdata_i;
        CFG_HALF:    cfg_d.half_size = cfg_wdata_i;
        CFG_BASIS_I: cfg_d.basis_i   = cfg_wdata_i;
        CFG_BASIS_J: cfg_d.basis_j   = cfg_wdata_i;
        CFG_BASIS_K: cfg_d.basis_k   = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center    <= '0;
      cfg_q.half_size <= '0;
      cfg_q.basis_i   <= BASIS_I_RST;
      cfg_q.basis_j   <= BASIS_J_RST;
      cfg_q.basis_k   <= BASIS_K_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  obbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .mid_valid_o (mid_valid),
    .mid_stall_i (mid_stall),
    .mid_o       (mid)
  );

  obbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_valid_i (mid_valid),
    .mid_stall_o (mid_stall),
    .mid_i       (mid),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ----- rtl/core/obbt_chk.sv -----
// ----------------------------------------------------------------------------
// obbt_chk
// Port-level checks for the oriented box core, bound to the top level.
// ----------------------------------------------------------------------------
module obbt_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input obbt_pkg::in_beat_t             in_beat_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input obbt_pkg::out_beat_t            out_beat_o
);
  import obbt_pkg::*;

  // A stalled input beat stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_beat_i))
    else $error("input beat changed while stalled");

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // Input only backs up when every stage is full and the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // Projection extremes are ordered
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(out_beat_o.range_min) <= $signed(out_beat_o.range_max))
    else $error("range_min above range_max");

  // A projection result carries no point, a point result no range
  a_field_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_beat_o.range_min != '0) || (out_beat_o.range_max != '0))
    |-> (out_beat_o.out_x == '0) && (out_beat_o.out_y == '0) && (out_beat_o.out_z == '0))
    else $error("point and range fields both set");

endmodule

bind obb_transform_and_axis_projection_core obbt_chk u_obbt_chk (.*);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oriented box transform and projection core.
// A directed script covers reset defaults, field extremes, every opcode,
// ignored register indexes and rounding ties. Randomized phases with fresh
// box settings follow. Every accepted beat is predicted in 64-bit integer
// math and matched in order against the output stream. Both sides idle and
// stall at random, with long receiver hold-offs that back up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import obbt_pkg::*;

  localparam int PIPE_LAT        = 6;
  localparam int CORNER_COUNT    = 8;
  localparam int RAND_ITEMS      = 1900;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_CYCLES     = 48;
  localparam int WATCHDOG_CYCLES = 2000;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      wdata;
    in_beat_t              beat;
    bit                    typed;
    out_beat_t             want;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_beat_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_beat_o;

  // Shadow copy of the box registers
  logic [CFG_W-1:0] box_regs [5];
  out_beat_t        box_results_due [$];
  script_row_t      script [$];

  int error_count  = 0;
  int beats_in     = 0;
  int beats_out    = 0;
  int burst_left   = 16;
  int quiet_cycles = 0;
  bit since_drain  = 1'b0;

  string beat_field_name [5] = '{"range_max", "range_min", "out_z", "out_y", "out_x"};

  obb_transform_and_axis_projection_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic note_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic longint lane_s(input logic [CFG_W-1:0] p, input int a);
    logic [VEC_W-1:0] f;
    f = p[16*a +: 16];
    return longint'($signed(f));
  endfunction

  // Round half up from s fraction bits, clamp to signed 16
  function automatic logic [VEC_W-1:0] round_clamp(input longint v, input int s);
    longint r;
    r = (v + (longint'(1) <<< (s - 1))) >>> s;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[VEC_W-1:0];
  endfunction

  function automatic out_beat_t obb_query_result(input in_beat_t b);
    out_beat_t        r;
    longint           v [3];
    longint           c [3];
    longint           h [3];
    longint           bs [3][3];
    longint           acc, proj, lo, hi, corner, si, sj, sk;
    logic [VEC_W-1:0] lane [3];
    logic [VEC_W-1:0] hf;
    int               a, n, k;
    r = '0;
    lo = 0;
    hi = 0;
    v[0] = b.vec_x;
    v[1] = b.vec_y;
    v[2] = b.vec_z;
    for (a = 0; a < 3; a++) begin
      lane[a] = '0;
      c[a] = lane_s(box_regs[CFG_CENTER], a);
      hf = box_regs[CFG_HALF][16*a +: 16];
      h[a] = longint'(hf);
      for (n = 0; n < 3; n++) bs[n][a] = lane_s(box_regs[CFG_BASIS_I + n], a);
    end
    case (op_e'(b.opcode))
      OP_W2L: begin
        for (n = 0; n < 3; n++) begin
          acc = 0;
          for (a = 0; a < 3; a++) acc += (v[a] - c[a]) * bs[n][a];
          lane[n] = round_clamp(acc, FRAC_LIN);
        end
      end
      OP_L2W: begin
        for (a = 0; a < 3; a++) begin
          acc = c[a] * 16384;
          for (n = 0; n < 3; n++) acc += v[n] * bs[n][a];
          lane[a] = round_clamp(acc, FRAC_LIN);
        end
      end
      OP_PROJ: begin
        // every corner is center +/- each weighted half axis
        for (k = 0; k < CORNER_COUNT; k++) begin
          si = k[2] ? 1 : -1;
          sj = k[1] ? 1 : -1;
          sk = k[0] ? 1 : -1;
          proj = 0;
          for (a = 0; a < 3; a++) begin
            corner = c[a] * 16384 + si * bs[0][a] * h[0] + sj * bs[1][a] * h[1]
                   + sk * bs[2][a] * h[2];
            proj += corner * v[a];
          end
          if (k == 0 || proj < lo) lo = proj;
          if (k == 0 || proj > hi) hi = proj;
        end
        r.range_min = round_clamp(lo, FRAC_PROJ);
        r.range_max = round_clamp(hi, FRAC_PROJ);
      end
      default: ;
    endcase
    r.out_x = lane[0];
    r.out_y = lane[1];
    r.out_z = lane[2];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  function automatic logic [VEC_W-1:0] pick_field();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return VEC_W'($urandom);
    endcase
  endfunction

  // Axis-aligned unit vector, either sign
  function automatic logic [CFG_W-1:0] unit_axis();
    logic [CFG_W-1:0] r;
    int               a;
    r = '0;
    a = $urandom_range(0, 2);
    r[16*a +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
    return r;
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
    script_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.wdata = data;
    row.beat  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  function automatic void add_beat(input op_e op, input logic [VEC_W-1:0] x,
                                   input logic [VEC_W-1:0] y,
                                   input logic [VEC_W-1:0] z,
                                   input bit typed = 1'b0,
                                   input out_beat_t want = '0);
    script_row_t row;
    row.kind        = ROW_BEAT;
    row.idx         = '0;
    row.wdata       = '0;
    row.beat.opcode = op;
    row.beat.vec_x  = x;
    row.beat.vec_y  = y;
    row.beat.vec_z  = z;
    row.typed       = typed;
    row.want        = want;
    script.push_back(row);
  endfunction

  // Offer one beat until taken, then maybe pause the sender
  task automatic offer_beat(input in_beat_t b, input out_beat_t want);
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    box_results_due.push_back(want);
    beats_in++;
    since_drain = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
  endtask

  // Wait until every result is back and the pipe is empty
  task automatic drain_pipe();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (box_results_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
    since_drain = 1'b0;
  endtask

  task automatic write_box_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_W-1:0] data);
    if (since_drain) drain_pipe();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= CFG_BASIS_K) box_regs[idx] = data;
    @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_beat_t                   want;
    logic [4:0][VEC_W-1:0]       got_f;
    logic [4:0][VEC_W-1:0]       want_f;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (box_results_due.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing outstanding", beats_out));
      end else begin
        want   = box_results_due.pop_front();
        got_f  = out_beat_o;
        want_f = want;
        for (int f = 4; f >= 0; f--) begin
          if (got_f[f] !== want_f[f]) begin
            note_error($sformatf("result %0d %s got %h want %h", beats_out,
                                 beat_field_name[f], got_f[f], want_f[f]));
          end
        end
      end
      beats_out++;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver stall pattern, with long hold-offs to back up the pipe
  // ------------------------------------------------------------------------
  initial begin : out_stall_gen
    int mode;
    int span;
    int tick;
    int holds_done;
    holds_done = 0;
    tick = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < 2 && beats_in >= (holds_done == 0 ? 400 : 1500)) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        repeat (span) begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 7) == 0);
            2:       out_stall_i <= $urandom_range(0, 1);
            default: out_stall_i <= (tick % 3 == 0);
          endcase
          tick++;
          @(posedge clk_i);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Watchdog: ends the run when nothing moves for too long
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("[%0t] no progress for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_CYCLES, box_results_due.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin : main_seq
    script_row_t      row;
    in_beat_t         nb;
    out_beat_t        want;
    logic [CFG_W-1:0] plan [5];
    int               phase, n, op_pick;

    box_regs[CFG_CENTER]  = '0;
    box_regs[CFG_HALF]    = '0;
    box_regs[CFG_BASIS_I] = BASIS_I_RST;
    box_regs[CFG_BASIS_J] = BASIS_J_RST;
    box_regs[CFG_BASIS_K] = BASIS_K_RST;

    // Reset defaults: identity basis, box at origin with no size
    add_beat(OP_W2L, 16'h7fff, 16'h8000, 16'h0001, 1'b1,
             out_beat_t'{16'h7fff, 16'h8000, 16'h0001, 16'h0000, 16'h0000});
    add_beat(OP_L2W, 16'h8000, 16'h7fff, 16'hfffe, 1'b1,
             out_beat_t'{16'h8000, 16'h7fff, 16'hfffe, 16'h0000, 16'h0000});
    add_beat(OP_PROJ, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, '0);
    add_beat(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 1'b1, '0);
    // Point box at (0x0100, 0xff00, 0); zero size projects to the center alone
    add_reg(CFG_CENTER, 48'h0000_ff00_0100);
    add_beat(OP_PROJ, 16'h4000, 16'h0000, 16'h0000, 1'b1,
             out_beat_t'{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100});
    add_beat(OP_W2L, 16'h0100, 16'hff00, 16'h0000, 1'b1, '0);
    // Writes past the register list leave the box alone
    add_reg(CFG_SPARE_LAST, 48'hffff_ffff_ffff);
    add_reg(CFG_SPARE_FIRST, 48'h1234_5678_9abc);
    add_beat(OP_L2W, 16'h0000, 16'h0000, 16'h0000, 1'b1,
             out_beat_t'{16'h0100, 16'hff00, 16'h0000, 16'h0000, 16'h0000});
    // Extreme box: non-unit bases, full half sizes, saturating results
    add_reg(CFG_CENTER,  48'h7fff_8000_7fff);
    add_reg(CFG_HALF,    48'hffff_ffff_ffff);
    add_reg(CFG_BASIS_I, 48'h7fff_7fff_7fff);
    add_reg(CFG_BASIS_J, 48'h8000_8000_8000);
    add_reg(CFG_BASIS_K, 48'hffff_ffff_ffff);
    add_beat(OP_W2L, 16'h8000, 16'h7fff, 16'h0000);
    add_beat(OP_W2L, 16'h7fff, 16'h7fff, 16'h7fff);
    add_beat(OP_L2W, 16'h7fff, 16'h7fff, 16'h7fff);
    add_beat(OP_L2W, 16'h8000, 16'h8000, 16'h8000);
    add_beat(OP_PROJ, 16'h7fff, 16'h8000, 16'h7fff);
    add_beat(OP_PROJ, 16'h8000, 16'h8000, 16'h8000);
    add_beat(OP_NONE, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, '0);
    // Half-scale basis puts results exactly on rounding ties
    add_reg(CFG_CENTER,  48'h0);
    add_reg(CFG_HALF,    48'h0000_0000_0001);
    add_reg(CFG_BASIS_I, 48'h0000_0000_2000);
    add_reg(CFG_BASIS_J, 48'h0);
    add_reg(CFG_BASIS_K, 48'h0);
    add_beat(OP_L2W, 16'h0001, 16'h0000, 16'h0000);
    add_beat(OP_L2W, 16'hffff, 16'h0000, 16'h0000);
    add_beat(OP_W2L, 16'hffff, 16'h0000, 16'h0000);
    add_beat(OP_PROJ, 16'h2000, 16'h0000, 16'h0000);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script
    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_REG) begin
        write_box_reg(row.idx, row.wdata);
      end else begin
        want = row.typed ? row.want : obb_query_result(row.beat);
        offer_beat(row.beat, want);
      end
    end

    // Random phases, each with its own box
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: for (n = CFG_CENTER; n <= CFG_BASIS_K; n++)
             plan[n] = {pick_field(), pick_field(), pick_field()};
        1: for (n = CFG_CENTER; n <= CFG_BASIS_K; n++) plan[n] = '1;
        2: begin
          for (n = CFG_CENTER; n <= CFG_BASIS_K; n++) plan[n] = {3{16'h8000}};
          plan[CFG_HALF] = {3{16'hffff}};
        end
        3: begin
          for (n = CFG_CENTER; n <= CFG_BASIS_K; n++) plan[n] = {3{16'h7fff}};
          plan[CFG_HALF] = '0;
        end
        default: begin
          plan[CFG_CENTER] = {pick_field(), pick_field(), pick_field()};
          plan[CFG_HALF]   = {VEC_W'($urandom_range(0, 2048)), VEC_W'($urandom_range(0, 2048)),
                              VEC_W'($urandom_range(0, 2048))};
          for (n = CFG_BASIS_I; n <= CFG_BASIS_K; n++)
            plan[n] = $urandom_range(0, 1) ? unit_axis()
                                           : {pick_field(), pick_field(), pick_field()};
        end
      endcase
      for (n = CFG_CENTER; n <= CFG_BASIS_K; n++) write_box_reg(CFG_IDX_W'(n), plan[n]);
      write_box_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                    CFG_W'({$urandom, $urandom}));

      repeat (RAND_ITEMS / NUM_PHASES) begin
        op_pick = $urandom_range(0, 15);
        nb.opcode = (op_pick < 5) ? OP_W2L : (op_pick < 10) ? OP_L2W :
                    (op_pick < 15) ? OP_PROJ : OP_NONE;
        nb.vec_x = pick_field();
        nb.vec_y = pick_field();
        nb.vec_z = pick_field();
        // About half of the W2L, L2W and PROJ queries stay in a useful range instead of saturating
        if (nb.opcode == OP_W2L && $urandom_range(0, 1)) begin
          nb.vec_x = box_regs[CFG_CENTER][15:0]  + VEC_W'($urandom_range(0, 2047)) - 16'd1024;
          nb.vec_y = box_regs[CFG_CENTER][31:16] + VEC_W'($urandom_range(0, 2047)) - 16'd1024;
          nb.vec_z = box_regs[CFG_CENTER][47:32] + VEC_W'($urandom_range(0, 2047)) - 16'd1024;
        end else if (nb.opcode == OP_L2W && $urandom_range(0, 1)) begin
          nb.vec_x = VEC_W'($urandom_range(0, 2047)) - 16'd1024;
          nb.vec_y = VEC_W'($urandom_range(0, 2047)) - 16'd1024;
          nb.vec_z = VEC_W'($urandom_range(0, 2047)) - 16'd1024;
        end else if (nb.opcode == OP_PROJ && $urandom_range(0, 1)) begin
          nb.vec_x = VEC_W'($urandom_range(0, 32768)) - 16'h4000;
          nb.vec_y = VEC_W'($urandom_range(0, 32768)) - 16'h4000;
          nb.vec_z = VEC_W'($urandom_range(0, 32768)) - 16'h4000;
        end
        offer_beat(nb, obb_query_result(nb));
      end
    end

    drain_pipe();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
